// ===== design/bfsa_pkg.sv =====
// Shared constants, operation codes and word types of the free-slot bitmap allocator.
package bfsa_pkg;

  localparam int MAP_BYTES   = 1024;
  localparam int DATA_W      = 8;
  localparam int INDEX_W     = 13;
  localparam int BYTE_W      = 10;
  localparam int BIT_W       = 3;
  localparam int INDEX_LIMIT = 8192;
  localparam int SCAN_BYTES  = (MAP_BYTES < INDEX_LIMIT / DATA_W) ? MAP_BYTES
                                                                  : INDEX_LIMIT / DATA_W;
  localparam int MAP_AW      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  localparam logic [DATA_W-1:0] FULL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FIND  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] bit_index;
    logic [INDEX_W-1:0] start_bit;
    logic [BYTE_W-1:0]  byte_index;
    logic [DATA_W-1:0]  byte_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] free_index;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t word;
  } res_t;

endpackage

// ===== design/bfsa_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bfsa_ctrl.sv =====
// Sequencer: clearing pass, read-modify-write of bitmap bytes and the byte scan of a find.
module bfsa_ctrl import bfsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output res_t              res,
  input  logic              res_ready,
  output logic              mem_we,
  output logic [MAP_AW-1:0] mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [MAP_AW-1:0] mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t             state;
  logic [MAP_AW-1:0]  clr_ptr;
  op_t                op_q;
  logic [BIT_W-1:0]   bit_q;
  logic [BYTE_W-1:0]  ptr;
  logic               first;
  logic [INDEX_W-1:0] start_q;
  logic               res_valid;
  rsp_t               res_word;

  logic               accept;
  logic [BYTE_W-1:0]  set_byte;
  logic [BYTE_W-1:0]  start_byte;
  logic               set_in_map;
  logic               load_in_map;
  logic               start_in_scan;
  logic [DATA_W-1:0]  bit_mask;
  logic [DATA_W-1:0]  low_mask;
  logic [DATA_W-1:0]  scan_v;
  logic               scan_hit;
  logic               scan_last;
  logic [BIT_W-1:0]   zero_pos;

  assign accept        = req_valid && (state == S_IDLE);
  assign req_stall     = (state != S_IDLE);
  assign set_byte      = req.bit_index[INDEX_W-1:BIT_W];
  assign start_byte    = req.start_bit[INDEX_W-1:BIT_W];
  assign set_in_map    = int'(set_byte) < MAP_BYTES;
  assign load_in_map   = int'(req.byte_index) < MAP_BYTES;
  assign start_in_scan = int'(start_byte) < SCAN_BYTES;

  assign bit_mask = DATA_W'(1) << bit_q;

  // on the start byte, bits below the start offset count as used
  assign low_mask  = first ? (bit_mask - DATA_W'(1)) : '0;
  assign scan_v    = mem_rdata | low_mask;
  assign scan_hit  = (scan_v != FULL_BYTE);
  assign scan_last = int'(ptr) >= SCAN_BYTES - 1;

  always_comb begin
    zero_pos = '0;
    for (int k = DATA_W - 1; k >= 0; k--) begin
      if (!scan_v[k]) begin
        zero_pos = BIT_W'(k);
      end
    end
  end

  // memory port drive
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_SET, OP_CLEAR: begin
              mem_re    = set_in_map;
              mem_raddr = MAP_AW'(set_byte);
            end
            OP_FIND: begin
              mem_re    = start_in_scan;
              mem_raddr = MAP_AW'(start_byte);
            end
            OP_LOAD: begin
              mem_we    = load_in_map;
              mem_waddr = MAP_AW'(req.byte_index);
              mem_wdata = req.byte_value;
            end
          endcase
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = MAP_AW'(ptr);
        mem_wdata = (op_q == OP_SET) ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
      end
      S_SCAN: begin
        // prefetch the following byte; unused when this byte hits or is the last
        mem_re    = 1'b1;
        mem_raddr = MAP_AW'(BYTE_W'(ptr + BYTE_W'(1)));
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + MAP_AW'(1);
          if (int'(clr_ptr) == MAP_BYTES - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op_q     <= req.op;
            start_q  <= req.start_bit;
            res_word <= '0;
            first    <= 1'b1;
            unique case (req.op)
              OP_SET, OP_CLEAR: begin
                bit_q     <= req.bit_index[BIT_W-1:0];
                ptr       <= set_byte;
                state     <= set_in_map ? S_RMW : S_RESULT;
                res_valid <= !set_in_map;
              end
              OP_FIND: begin
                bit_q     <= req.start_bit[BIT_W-1:0];
                ptr       <= start_byte;
                state     <= start_in_scan ? S_SCAN : S_RESULT;
                res_valid <= !start_in_scan;
              end
              OP_LOAD: begin
                state     <= S_RESULT;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RMW: begin
          state     <= S_RESULT;
          res_valid <= 1'b1;
        end
        S_SCAN: begin
          first <= 1'b0;
          if (scan_hit) begin
            res_word.found      <= 1'b1;
            res_word.free_index <= {ptr, zero_pos};
            res_valid           <= 1'b1;
            state               <= S_RESULT;
          end else if (scan_last) begin
            res_valid <= 1'b1;
            state     <= S_RESULT;
          end else begin
            ptr <= ptr + BYTE_W'(1);
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res = {res_valid, res_word};

  a_found_at_or_above_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.found |-> res_word.free_index >= start_q)
    else $error("found index below start bit");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.found |-> res_word.free_index == '0)
    else $error("not-found result with nonzero index");

  a_only_find_hits: assert property (@(posedge clk) disable iff (rst)
    res_valid && (op_q != OP_FIND) |-> !res_word.found)
    else $error("non-find operation reported a hit");

  a_rmw_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |-> $past(mem_re) && $past(state) == S_IDLE)
    else $error("byte update without a preceding read");

endmodule

// ===== design/bitmap_free_slot_allocator.sv =====
// Top level of the free-slot bitmap allocator: sequencer, bitmap RAM and result register.
//
// Keeps a usage bitmap of MAP_BYTES bytes (bit b of byte k is slot 8*k+b, 1 = used) in a
// single RAM with a registered read. One request word is handled at a time:
// a load goes straight to its result, a set or clear reads the byte, then modifies and
// writes it back, and a find scans one byte per cycle through the RAM read port
// with the next byte prefetched, up to a free bit or the end of the map.
// Set, clear and load with a byte outside the map are dropped and still answered with
// found = 0 and free_index = 0; a find that reaches the end of the map (or slot 8191)
// without a free bit answers found = 0, free_index = 0. After reset the block sweeps
// the RAM to all zero, one byte per cycle, holding req_stall high meanwhile. Results
// sit in an output register, so the next request word is taken while a finished
// response word still waits on rsp_stall.
module bitmap_free_slot_allocator import bfsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  res_t              res;
  logic              res_ready;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [MAP_AW-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  bfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // usage bitmap
  bfsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: refills when empty or when its word leaves this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res.valid;
      if (res.valid) begin
        rsp <= res.word;
      end
    end
  end

endmodule

// ===== tb/slot_map_checker.sv =====
// Bus monitor, bitmap predictor and response scoreboard for the free-slot allocator bench.
module slot_map_checker import bfsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   finds_hit,
  output int   finds_missed
);

  logic [DATA_W-1:0] usage [MAP_BYTES];
  rsp_t expected_rsp [$];

  // Applies one request word to the shadow bitmap; returns the response word it owes.
  function automatic rsp_t bitmap_step(input req_t w);
    rsp_t r;
    int unsigned slot_byte, j, k, idx;
    r = '0;
    case (w.op)
      OP_SET, OP_CLEAR: begin
        slot_byte = w.bit_index / DATA_W;
        if (slot_byte < MAP_BYTES)
          usage[slot_byte][w.bit_index % DATA_W] = (w.op == OP_SET);
      end
      OP_LOAD: begin
        if (w.byte_index < MAP_BYTES)
          usage[w.byte_index] = w.byte_value;
      end
      OP_FIND: begin
        // full bytes are skipped; bits below the start inside the start byte don't count
        for (j = w.start_bit / DATA_W; j < SCAN_BYTES && !r.found; j++) begin
          if (usage[j] != FULL_BYTE) begin
            for (k = 0; k < DATA_W && !r.found; k++) begin
              idx = j * DATA_W + k;
              if (!usage[j][k] && idx >= w.start_bit) begin
                r.found      = 1'b1;
                r.free_index = INDEX_W'(idx);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      for (int i = 0; i < MAP_BYTES; i++)
        usage[i] = '0;
      expected_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected response word found=%0b free_index=%0d",
                   $time, rsp.found, rsp.free_index);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, rsp.found);
          end
          if (rsp.free_index !== want.free_index) begin
            errors++;
            $display("%0t: free_index expected %0d actual %0d",
                     $time, want.free_index, rsp.free_index);
          end
        end
      end
      if (req_valid && !req_stall) begin
        got = bitmap_step(req);
        if (req.op == OP_FIND) begin
          if (got.found)
            finds_hit++;
          else
            finds_missed++;
        end
        expected_rsp.push_back(got);
      end
    end
    // nonblocking so the stimulus side always reads the count as of the previous edge
    pending <= expected_rsp.size();
  end

endmodule

// ===== tb/bitmap_free_slot_allocator_tb.sv =====
// Stimulus, flow control and verdict for the free-slot bitmap allocator bench.
module bitmap_free_slot_allocator_tb;
  import bfsa_pkg::*;

  localparam int ITEMS           = 1950;
  localparam int RSP_HOLD_CYCLES = 400;  // long receiver hold-off, fills the block
  localparam int TAIL_BYTES      = 128;  // map tail filled once for a long scan
  localparam int SETTLE_CYCLES   = 64;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  int errors, pending, finds_hit, finds_missed;

  // jitter gates random idling on both sides; hold_rsp asks the receiver for a long hold-off
  bit jitter   = 1'b1;
  bit hold_rsp = 1'b0;

  int sent;
  int sent_by_op [4];

  always #2 clk = ~clk;

  bitmap_free_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  slot_map_checker chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .finds_hit    (finds_hit),
    .finds_missed (finds_missed)
  );

  // Request word with every field random; the caller overrides what the op uses.
  function automatic req_t noise_word(input op_t op);
    req_t w;
    w.op         = op;
    w.bit_index  = INDEX_W'($urandom);
    w.start_bit  = INDEX_W'($urandom);
    w.byte_index = BYTE_W'($urandom);
    w.byte_value = DATA_W'($urandom);
    return w;
  endfunction

  // Directed words: slot feeds both bit_index and start_bit.
  function automatic req_t make_word(input op_t op, input int unsigned slot,
                                     input int unsigned byte_sel, input int unsigned val);
    req_t w;
    w.op         = op;
    w.bit_index  = INDEX_W'(slot);
    w.start_bit  = INDEX_W'(slot);
    w.byte_index = BYTE_W'(byte_sel);
    w.byte_value = DATA_W'(val);
    return w;
  endfunction

  // Offers one word, after an optional random idle burst, and returns at its accept edge.
  // Valid stays high on return so back-to-back words need no toggle.
  task automatic issue(input req_t w);
    if (jitter && $urandom_range(7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent++;
    sent_by_op[w.op]++;
  endtask

  // Drops valid and waits until every response word owed has been taken.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Well-formed burst: mark a run of bytes full, maybe a partial byte after it, then
  // finds that start in or just before the run, mixed with sets and clears nearby.
  task automatic region_burst();
    int unsigned base, len, i;
    req_t w;
    base = $urandom_range(MAP_BYTES - 1);
    len  = $urandom_range(12, 1);
    for (i = 0; i < len && base + i < MAP_BYTES; i++) begin
      w = noise_word(OP_LOAD);
      w.byte_index = BYTE_W'(base + i);
      w.byte_value = FULL_BYTE;
      issue(w);
    end
    if ($urandom_range(1) && base + len < MAP_BYTES) begin
      w = noise_word(OP_LOAD);
      w.byte_index = BYTE_W'(base + len);
      issue(w);
    end
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(1)) begin
        w = noise_word(op_t'($urandom_range(1) ? OP_SET : OP_CLEAR));
        w.bit_index = INDEX_W'(base * DATA_W + $urandom_range(len * DATA_W + 7));
        issue(w);
      end
      w = noise_word(OP_FIND);
      if ($urandom_range(3) == 0)
        w.start_bit = INDEX_W'((base > 0 ? base - 1 : 0) * DATA_W + $urandom_range(7));
      else
        w.start_bit = INDEX_W'(base * DATA_W + $urandom_range(7));
      issue(w);
    end
    // often hand the run back, so scans stay short
    if ($urandom_range(1)) begin
      for (i = 0; i < len && base + i < MAP_BYTES; i++) begin
        w = noise_word(OP_LOAD);
        w.byte_index = BYTE_W'(base + i);
        w.byte_value = $urandom_range(3) == 0 ? DATA_W'($urandom) : '0;
        issue(w);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rsp_side
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_rsp = 1'b0;
      end else if (jitter && $urandom_range(7) == 0) begin
        n = $urandom_range(6, 1);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: sized for every find scanning the whole map behind worst-case stalls.
  initial begin : watchdog
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    req_t w;
    int unsigned i, pick;
    bit held, tail_done, paused;
    held      = 1'b0;
    tail_done = 1'b0;
    paused    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // the block clears its RAM after reset with req_stall high; issue() just waits it out

    // ---- directed part ----
    issue(make_word(OP_FIND, 0, 0, 0));          // empty map: slot 0
    issue(make_word(OP_FIND, 8191, 0, 0));       // top slot, start byte is the last byte
    issue(make_word(OP_SET, 0, 0, 0));
    issue(make_word(OP_SET, 8191, 0, 0));
    issue(make_word(OP_FIND, 0, 0, 0));          // slot 0 used: expect 1
    issue(make_word(OP_FIND, 8191, 0, 0));       // nothing free at or above the start
    issue(make_word(OP_CLEAR, 8191, 0, 0));
    issue(make_word(OP_CLEAR, 8191, 0, 0));      // clear of a free slot keeps it free
    issue(make_word(OP_FIND, 8191, 0, 0));
    issue(make_word(OP_LOAD, 0, 0, 255));
    issue(make_word(OP_LOAD, 0, 1, 255));
    issue(make_word(OP_LOAD, 0, 2, 8'h0F));
    issue(make_word(OP_FIND, 0, 0, 0));          // skips two full bytes: expect 20
    issue(make_word(OP_LOAD, 0, 3, 8'hA5));
    issue(make_word(OP_FIND, 26, 0, 0));         // free bit 1 below start ignored: expect 27
    issue(make_word(OP_FIND, 31, 0, 0));         // top bit of start byte used: expect 32
    issue(make_word(OP_LOAD, 0, 1023, 255));
    issue(make_word(OP_FIND, 8184, 0, 0));       // last byte full: not found
    issue(make_word(OP_LOAD, 0, 1023, 8'h7F));
    issue(make_word(OP_FIND, 8184, 0, 0));       // expect 8191
    issue(make_word(OP_LOAD, 0, 1023, 0));
    issue(make_word(OP_CLEAR, 0, 0, 0));
    issue(make_word(OP_LOAD, 0, 0, 0));
    issue(make_word(OP_FIND, 4095, 0, 0));

    // ---- random part ----
    while (sent < ITEMS) begin
      if (!held && sent >= 600) begin
        held = 1'b1;
        hold_rsp = 1'b1;                         // sender keeps offering meanwhile
      end
      if (!tail_done && sent >= 900) begin
        tail_done = 1'b1;
        // long scan: fill the top of the map, then look for space up there
        for (i = MAP_BYTES - TAIL_BYTES; i < MAP_BYTES; i++)
          issue(make_word(OP_LOAD, 0, i, 255));
        issue(make_word(OP_FIND, (MAP_BYTES - TAIL_BYTES) * DATA_W, 0, 0));
        issue(make_word(OP_FIND, 8191, 0, 0));
        issue(make_word(OP_LOAD, 0, MAP_BYTES - 1, 8'h7F));
        issue(make_word(OP_FIND, (MAP_BYTES - TAIL_BYTES) * DATA_W, 0, 0));
      end
      if (!paused && sent >= 1200) begin
        paused = 1'b1;
        drain();
      end
      if (sent >= ITEMS - 200)
        jitter = 1'b0;

      pick = $urandom_range(9);
      if (pick < 4) begin
        region_burst();
      end else begin
        w = noise_word(op_t'($urandom_range(3)));
        if (w.op == OP_LOAD) begin
          case ($urandom_range(2))
            0:       w.byte_value = '0;
            1:       w.byte_value = FULL_BYTE;
            default: ;
          endcase
        end
        issue(w);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d request words: %0d set, %0d clear, %0d find, %0d load",
             sent, sent_by_op[OP_SET], sent_by_op[OP_CLEAR], sent_by_op[OP_FIND],
             sent_by_op[OP_LOAD]);
    $display("finds with a free slot %0d, without %0d; long hold-off and full drain done",
             finds_hit, finds_missed);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
